@@ src/aabb_rigid_transform_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rigid box transform unit
// Immediate-consequence and next-cycle forms; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef AABB_RIGID_TRANSFORM_UNIT_ASSERT_SVH
`define AABB_RIGID_TRANSFORM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ART_ASSERT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ART_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ART_ASSERT(name, clk, rst, ante, cons)
`define ART_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ src/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, constants and saturation helper for the box transform.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 8;
   localparam int NUM_STAGES  = 8;
   localparam int CSR_AW      = 3;
   localparam int SCALE_SHIFT = 16;
   localparam int CROSS_SHIFT = 30;
   localparam int TERM_SHIFT  = 29;

   typedef logic signed [31:0] fix_type;
   typedef logic signed [65:0] wide_type;
   typedef fix_type vec3_type [NUM_AXES];

   typedef enum logic [CSR_AW-1:0] {
      CSR_SCALE_X = 3'd0,
      CSR_SCALE_Y = 3'd1,
      CSR_SCALE_Z = 3'd2,
      CSR_ROT_W   = 3'd3,
      CSR_ROT_X   = 3'd4,
      CSR_ROT_Y   = 3'd5,
      CSR_ROT_Z   = 3'd6
   } csr_idx_type;

   localparam fix_type SCALE_RESET = 32'sd65536;
   localparam fix_type ROT_W_RESET = 32'sd1073741824;
   localparam fix_type ROT_V_RESET = 32'sd0;

   localparam wide_type SAT_MAX = 66'sd2147483647;
   localparam wide_type SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      logic en_prod;
      logic en_cross;
      logic en_term;
      logic en_sum;
   } lane_ctl_type;

   typedef struct packed {
      logic en_bound;
      logic en_out;
   } red_ctl_type;

   // clamp to the signed 32-bit range
   function automatic fix_type sat32(input wide_type x);
      fix_type res;
      if (x > SAT_MAX) begin
         res = fix_type'(SAT_MAX[31:0]);
      end else if (x < SAT_MIN) begin
         res = fix_type'(SAT_MIN[31:0]);
      end else begin
         res = fix_type'(x[31:0]);
      end
      return res;
   endfunction

endpackage

@@ src/art_req_if.sv @@
// ----------------------------------------------------------------------------
// art_req_if
// Box request channel: center, half-extents and translation.
// ----------------------------------------------------------------------------
interface art_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] center_z;
   logic [30:0]        half_x;
   logic [30:0]        half_y;
   logic [30:0]        half_z;
   logic signed [31:0] move_x;
   logic signed [31:0] move_y;
   logic signed [31:0] move_z;

   modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                   move_x, move_y, move_z, input ready);
   modport sink (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                 move_x, move_y, move_z, output ready);
endinterface

@@ src/art_rsp_if.sv @@
// ----------------------------------------------------------------------------
// art_rsp_if
// Box result channel: enclosing center and half-extents.
// ----------------------------------------------------------------------------
interface art_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_center_x;
   logic signed [31:0] new_center_y;
   logic signed [31:0] new_center_z;
   logic [30:0]        new_half_x;
   logic [30:0]        new_half_y;
   logic [30:0]        new_half_z;

   modport source (output valid, new_center_x, new_center_y, new_center_z, new_half_x,
                   new_half_y, new_half_z, input ready);
   modport sink (input valid, new_center_x, new_center_y, new_center_z, new_half_x,
                 new_half_y, new_half_z, output ready);
endinterface

@@ src/art_corner.sv @@
// ----------------------------------------------------------------------------
// art_corner
// One corner lane: quaternion rotation and translation over four stages.
// ----------------------------------------------------------------------------
module art_corner (
   input  logic                  clock,
   input  art_pkg::lane_ctl_type ctl,
   input  art_pkg::vec3_type     v_in,
   input  art_pkg::vec3_type     q_in,
   input  art_pkg::fix_type      w_in,
   input  art_pkg::vec3_type     m_in,
   output art_pkg::vec3_type     r_out
);
   import art_pkg::*;

   logic signed [63:0] pa_ff [NUM_AXES];
   logic signed [63:0] pb_ff [NUM_AXES];
   logic signed [63:0] pa_in [NUM_AXES];
   logic signed [63:0] pb_in [NUM_AXES];
   vec3_type           v2_ff, v3_ff, v4_ff;
   vec3_type           t_ff, t_in;
   logic signed [63:0] wt_ff [NUM_AXES];
   logic signed [63:0] ta_ff [NUM_AXES];
   logic signed [63:0] tb_ff [NUM_AXES];
   logic signed [63:0] wt_in [NUM_AXES];
   logic signed [63:0] ta_in [NUM_AXES];
   logic signed [63:0] tb_in [NUM_AXES];
   vec3_type           r_ff, r_in;

   // q x v as two product halves per component
   always_comb begin
      pa_in[0] = q_in[1] * v_in[2];
      pb_in[0] = q_in[2] * v_in[1];
      pa_in[1] = q_in[2] * v_in[0];
      pb_in[1] = q_in[0] * v_in[2];
      pa_in[2] = q_in[0] * v_in[1];
      pb_in[2] = q_in[1] * v_in[0];
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         t_in[i] = sat32((66'(pa_ff[i]) - 66'(pb_ff[i])) >>> CROSS_SHIFT);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         wt_in[i] = w_in * t_ff[i];
      end
      ta_in[0] = q_in[1] * t_ff[2];
      tb_in[0] = q_in[2] * t_ff[1];
      ta_in[1] = q_in[2] * t_ff[0];
      tb_in[1] = q_in[0] * t_ff[2];
      ta_in[2] = q_in[0] * t_ff[1];
      tb_in[2] = q_in[1] * t_ff[0];
   end

   always_comb begin
      fix_type a, b;
      for (int i = 0; i < NUM_AXES; i++) begin
         a = sat32(66'(wt_ff[i]) >>> TERM_SHIFT);
         b = sat32((66'(ta_ff[i]) - 66'(tb_ff[i])) >>> TERM_SHIFT);
         r_in[i] = sat32(66'(v4_ff[i]) + 66'(a) + 66'(b) + 66'(m_in[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_prod) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         v2_ff <= v_in;
      end
      if (ctl.en_cross) begin
         t_ff  <= t_in;
         v3_ff <= v2_ff;
      end
      if (ctl.en_term) begin
         wt_ff <= wt_in;
         ta_ff <= ta_in;
         tb_ff <= tb_in;
         v4_ff <= v3_ff;
      end
      if (ctl.en_sum) begin
         r_ff <= r_in;
      end
   end

   assign r_out = r_ff;

endmodule

@@ src/art_reduce.sv @@
// ----------------------------------------------------------------------------
// art_reduce
// Per-axis bounds over the corners, then center and half-extent.
// ----------------------------------------------------------------------------
module art_reduce (
   input  logic                 clock,
   input  art_pkg::red_ctl_type ctl,
   input  art_pkg::vec3_type    corner_r [art_pkg::NUM_CORNERS],
   output art_pkg::vec3_type    center_out,
   output logic [30:0]          half_out [art_pkg::NUM_AXES]
);
   import art_pkg::*;

   vec3_type    lo_ff, hi_ff, lo_in, hi_in;
   vec3_type    center_ff, center_in;
   logic [30:0] half_ff [NUM_AXES];
   logic [30:0] half_in [NUM_AXES];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         lo_in[i] = corner_r[0][i];
         hi_in[i] = corner_r[0][i];
         for (int k = 1; k < NUM_CORNERS; k++) begin
            if (corner_r[k][i] < lo_in[i]) begin
               lo_in[i] = corner_r[k][i];
            end
            if (corner_r[k][i] > hi_in[i]) begin
               hi_in[i] = corner_r[k][i];
            end
         end
      end
   end

   always_comb begin
      logic signed [32:0] sum, dif;
      for (int i = 0; i < NUM_AXES; i++) begin
         sum = 33'(lo_ff[i]) + 33'(hi_ff[i]);
         dif = 33'(hi_ff[i]) - 33'(lo_ff[i]);
         center_in[i] = fix_type'(sum[32:1]);
         half_in[i]   = dif[31:1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_bound) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (ctl.en_out) begin
         center_ff <= center_in;
         half_ff   <= half_in;
      end
   end

   assign center_out = center_ff;
   assign half_out   = half_ff;

endmodule

@@ src/aabb_rigid_transform_unit.sv @@
// ----------------------------------------------------------------------------
// aabb_rigid_transform_unit
// Scales, rotates and translates a box and returns its enclosing box.
// ----------------------------------------------------------------------------
// Usage: send one box per transaction on req_chan (center, half-extents,
// translation); the enclosing box comes back on rsp_chan, one transaction
// per box, in order. Scale and the unit quaternion sit in csr registers,
// written through csr_we/csr_addr/csr_wdata while nothing is in flight.
// Pipeline: each stage registers its result; the last drives rsp_chan.valid.
// Throughput: one box per cycle unless stalled; eight corner lanes run
// in parallel and each pipeline stage holds at most one multiplier per path.
// Stall: each stage has its own valid bit and advances when its successor
// is free, so bubbles collapse and the input keeps accepting until every
// stage holds a box. A stalled result holds in the output register.
// Reset: clears all valid bits and loads unit scale and identity rotation.
// ----------------------------------------------------------------------------
`include "aabb_rigid_transform_unit_assert.svh"

module aabb_rigid_transform_unit (
   input  logic                         clock,
   input  logic                         reset,
   art_req_if.sink                      req_chan,
   art_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [art_pkg::CSR_AW-1:0]   csr_addr,
   input  logic signed [31:0]           csr_wdata
);
   import art_pkg::*;

   // configuration registers
   vec3_type scale_ff, rot_v_ff;
   fix_type  rot_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '{SCALE_RESET, SCALE_RESET, SCALE_RESET};
         rot_v_ff <= '{ROT_V_RESET, ROT_V_RESET, ROT_V_RESET};
         rot_w_ff <= ROT_W_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_SCALE_X: scale_ff[0] <= csr_wdata;
            CSR_SCALE_Y: scale_ff[1] <= csr_wdata;
            CSR_SCALE_Z: scale_ff[2] <= csr_wdata;
            CSR_ROT_W:   rot_w_ff    <= csr_wdata;
            CSR_ROT_X:   rot_v_ff[0] <= csr_wdata;
            CSR_ROT_Y:   rot_v_ff[1] <= csr_wdata;
            CSR_ROT_Z:   rot_v_ff[2] <= csr_wdata;
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // stage valid bits and per-stage advance
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] en;
   logic                  in_acc, out_acc;

   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_chan.ready = en[0];
   assign in_acc         = req_chan.valid && en[0];
   assign out_acc        = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 0: corner coordinates per axis, exact in 33 bits
   logic signed [32:0] p_hi_ff [NUM_AXES];
   logic signed [32:0] p_lo_ff [NUM_AXES];
   logic signed [32:0] p_hi_in [NUM_AXES];
   logic signed [32:0] p_lo_in [NUM_AXES];
   vec3_type           c_in, m_in;
   logic [30:0]        h_in [NUM_AXES];
   vec3_type           m0_ff, m1_ff, m2_ff, m3_ff, m4_ff;

   assign c_in = '{req_chan.center_x, req_chan.center_y, req_chan.center_z};
   assign h_in = '{req_chan.half_x, req_chan.half_y, req_chan.half_z};
   assign m_in = '{req_chan.move_x, req_chan.move_y, req_chan.move_z};

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         p_hi_in[i] = 33'(c_in[i]) + signed'({2'b00, h_in[i]});
         p_lo_in[i] = 33'(c_in[i]) - signed'({2'b00, h_in[i]});
      end
   end

   // stage 1: per-axis scale of both corner coordinates
   vec3_type v_hi_ff, v_lo_ff, v_hi_in, v_lo_in;

   always_comb begin
      logic signed [64:0] ph, pl;
      for (int i = 0; i < NUM_AXES; i++) begin
         ph = p_hi_ff[i] * scale_ff[i];
         pl = p_lo_ff[i] * scale_ff[i];
         v_hi_in[i] = sat32(66'(ph) >>> SCALE_SHIFT);
         v_lo_in[i] = sat32(66'(pl) >>> SCALE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         m0_ff   <= m_in;
      end
      if (en[1]) begin
         v_hi_ff <= v_hi_in;
         v_lo_ff <= v_lo_in;
         m1_ff   <= m0_ff;
      end
      // advance the translation alongside the corner lanes
      if (en[2]) begin
         m2_ff <= m1_ff;
      end
      if (en[3]) begin
         m3_ff <= m2_ff;
      end
      if (en[4]) begin
         m4_ff <= m3_ff;
      end
   end

   // stages 2 to 5: eight corner lanes
   lane_ctl_type lane_ctl;
   vec3_type     corner_r [NUM_CORNERS];

   assign lane_ctl = '{en_prod: en[2], en_cross: en[3], en_term: en[4], en_sum: en[5]};

   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
      localparam logic [NUM_AXES-1:0] Sel = NUM_AXES'(k);
      vec3_type v_sel;

      always_comb begin
         for (int i = 0; i < NUM_AXES; i++) begin
            v_sel[i] = Sel[i] ? v_hi_ff[i] : v_lo_ff[i];
         end
      end

      art_corner u_corner (
         .clock (clock),
         .ctl   (lane_ctl),
         .v_in  (v_sel),
         .q_in  (rot_v_ff),
         .w_in  (rot_w_ff),
         .m_in  (m4_ff),
         .r_out (corner_r[k])
      );
   end

   // stages 6 and 7: bounds, then center and half-extent
   red_ctl_type red_ctl;
   vec3_type    new_center;
   logic [30:0] new_half [NUM_AXES];

   assign red_ctl = '{en_bound: en[6], en_out: en[7]};

   art_reduce u_reduce (
      .clock      (clock),
      .ctl        (red_ctl),
      .corner_r   (corner_r),
      .center_out (new_center),
      .half_out   (new_half)
   );

   assign rsp_chan.valid        = vld_ff[NUM_STAGES-1];
   assign rsp_chan.new_center_x = new_center[0];
   assign rsp_chan.new_center_y = new_center[1];
   assign rsp_chan.new_center_z = new_center[2];
   assign rsp_chan.new_half_x   = new_half[0];
   assign rsp_chan.new_half_y   = new_half[1];
   assign rsp_chan.new_half_z   = new_half[2];

   // a full, stalled pipeline must refuse new transactions
   `ART_ASSERT(a_full_blocks, clock, reset, (&vld_ff) && !rsp_chan.ready, !req_chan.ready)
   // occupancy tracks accepted minus delivered transactions
   `ART_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, $countones(vld_ff) == $countones($past(vld_ff)) + 32'($past(in_acc)) - 32'($past(out_acc)))

endmodule
